/* src/scvp_pkg.sv */
package scvp_pkg;

    // Fixed field widths
    localparam int unsigned PULSE_W = 11;
    localparam int unsigned MAG_W   = 11;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned CFG_W   = 16;

    localparam logic [MAG_W-1:0]   MAG_MAX       = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_BASE    = 11'd1000;
    localparam logic [PULSE_W-1:0] RESET_PULSE   = 11'd1500;
    localparam logic [TIME_W-1:0]  RESET_TIMEOUT = 16'd500;
    localparam logic [TIME_W-1:0]  TIME_MAX      = 16'hFFFF;

    // Register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_NEUTRAL = 1'b1;

    // Item kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Characters
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;

    // STOP word tracker
    localparam logic [2:0] STOP_NONE = 3'd0;
    localparam logic [2:0] STOP_S    = 3'd1;
    localparam logic [2:0] STOP_FULL = 3'd4;
    localparam logic [2:0] STOP_DEAD = 3'd7;

    // Number sub-phases
    localparam logic [1:0] NUM_WS   = 2'd0;
    localparam logic [1:0] NUM_SIGN = 2'd1;
    localparam logic [1:0] NUM_DIG  = 2'd2;
    localparam logic [1:0] NUM_DONE = 2'd3;

    typedef enum logic [9:0] {
        PH_LEAD     = 10'b00_0000_0001,
        PH_JUNK     = 10'b00_0000_0010,
        PH_SPD_WS   = 10'b00_0000_0100,
        PH_SPD_SIGN = 10'b00_0000_1000,
        PH_SPD_DIG  = 10'b00_0001_0000,
        PH_SPD_DONE = 10'b00_0010_0000,
        PH_STR_WS   = 10'b00_0100_0000,
        PH_STR_SIGN = 10'b00_1000_0000,
        PH_STR_DIG  = 10'b01_0000_0000,
        PH_STR_DONE = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] steer_us;
        logic [PULSE_W-1:0] throttle_us;
        logic               drive_applied;
        logic               stop_applied;
        logic               failsafe_active;
    } out_item_t;

    typedef struct packed {
        logic [1:0]       sub;
        logic [MAG_W-1:0] mag;
        logic             neg;
    } num_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] stop_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = CH_S;
            2'd1:    ch = CH_T;
            2'd2:    ch = CH_O;
            default: ch = CH_P;
        endcase
        return ch;
    endfunction

    // m*10 + digit, saturated
    function automatic logic [MAG_W-1:0] add_digit(input logic [MAG_W-1:0] m,
                                                    input logic [7:0] c);
        logic [14:0] v;
        v = {1'b0, m, 3'b000} + {3'b000, m, 1'b0} + {11'd0, 4'(c - CH_ZERO)};
        return (v > 15'(MAG_MAX)) ? MAG_MAX : v[MAG_W-1:0];
    endfunction

    function automatic logic [PULSE_W-1:0] to_pulse(input logic [MAG_W-1:0] mag,
                                                    input logic neg);
        logic [MAG_W-1:0] m;
        logic [MAG_W-1:0] s;
        m = (mag > MAG_MAX) ? MAG_MAX : mag;
        s = neg ? (MAG_MAX - m) : (MAG_MAX + m);
        return PULSE_BASE + {1'b0, s[MAG_W-1:1]};
    endfunction

    // One atol step on a non-newline byte
    function automatic num_t number_step(input num_t cur, input logic [7:0] c);
        num_t r;
        r = cur;
        unique case (cur.sub)
            NUM_WS: begin
                if (!is_blank(c)) begin
                    if ((c == CH_MINUS) || (c == CH_PLUS)) begin
                        r.neg = (c == CH_MINUS);
                        r.sub = NUM_SIGN;
                    end else if (is_digit(c)) begin
                        r.mag = add_digit(cur.mag, c);
                        r.sub = NUM_DIG;
                    end else begin
                        r.sub = NUM_DONE;
                    end
                end
            end
            NUM_SIGN, NUM_DIG: begin
                if (is_digit(c)) begin
                    r.mag = add_digit(cur.mag, c);
                    r.sub = NUM_DIG;
                end else begin
                    r.sub = NUM_DONE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

endpackage

/* src/serial_command_to_servo_pulse.sv */
// Serial command to servo pulse converter.
//
// Input channel (in_valid / in_stall / in_data): each request is either one
// received serial byte (cmd = 0) or a one millisecond tick (cmd = 1). Lines
// "STOP" and "S<speed> <steer>" ending in newline set the servo pulses; a
// silence longer than the failsafe timeout forces both pulses to neutral_us.
// Output channel (out_valid / out_stall / out_data): exactly one result per
// request, carrying the pulse widths after that request plus event flags.
// The result is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while no result is stalled; the whole parse step for a byte is one
// pass through the state update logic into the state and output registers.
// Stalling: while a result waits under out_stall, in_stall is raised; when
// the result is taken in the same cycle a new request is taken too.
// Configuration (cfg_we / cfg_index / cfg_wdata): index 0 is the failsafe
// timeout in ms, index 1 is neutral_us; write only while idle.
// Reset: line parser cleared, timer zero, both pulses 1500 us, timeout 500 ms,
// neutral 1500 us, no result pending.
module serial_command_to_servo_pulse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  scvp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output scvp_pkg::out_item_t out_data
);
    import scvp_pkg::*;

    // Configuration
    logic [TIME_W-1:0]  timeout_reg;
    logic [PULSE_W-1:0] neutral_reg;

    // Line parser state
    phase_t             phase_reg, phase_next;
    logic [2:0]         stop_reg, stop_next;
    logic [MAG_W-1:0]   spd_mag_reg, spd_mag_next;
    logic               spd_neg_reg, spd_neg_next;
    logic [MAG_W-1:0]   str_mag_reg, str_mag_next;
    logic               str_neg_reg, str_neg_next;
    logic [1:0]         flags_reg, flags_next;   // bit0 speed seen, bit1 steer seen

    // Timer and pulses
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic [PULSE_W-1:0] steer_reg, steer_next;
    logic [PULSE_W-1:0] throttle_reg, throttle_next;

    // Output register
    logic               out_valid_reg;
    out_item_t          out_data_reg, out_data_next;

    logic               accept;
    logic [7:0]         c;
    logic               blank;
    logic               in_spd, in_str;
    num_t               spd_cur, spd_new, str_cur, str_new;
    logic               drive, stop_hit, failsafe;

    // A waiting result blocks new requests only while it is stalled
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign c     = in_data.rx_byte;
    assign blank = is_blank(c);

    assign in_spd = (phase_reg == PH_SPD_WS) || (phase_reg == PH_SPD_SIGN) ||
                    (phase_reg == PH_SPD_DIG) || (phase_reg == PH_SPD_DONE);
    assign in_str = (phase_reg == PH_STR_WS) || (phase_reg == PH_STR_SIGN) ||
                    (phase_reg == PH_STR_DIG) || (phase_reg == PH_STR_DONE);

    // Sub-phase of the number being read
    always_comb
    begin
        spd_cur.mag = spd_mag_reg;
        spd_cur.neg = spd_neg_reg;
        str_cur.mag = str_mag_reg;
        str_cur.neg = str_neg_reg;
        case (phase_reg)
            PH_SPD_SIGN: spd_cur.sub = NUM_SIGN;
            PH_SPD_DIG:  spd_cur.sub = NUM_DIG;
            PH_SPD_DONE: spd_cur.sub = NUM_DONE;
            default:     spd_cur.sub = NUM_WS;
        endcase
        case (phase_reg)
            PH_STR_SIGN: str_cur.sub = NUM_SIGN;
            PH_STR_DIG:  str_cur.sub = NUM_DIG;
            PH_STR_DONE: str_cur.sub = NUM_DONE;
            default:     str_cur.sub = NUM_WS;
        endcase
    end

    assign spd_new = number_step(spd_cur, c);
    assign str_new = number_step(str_cur, c);

    // Per-request state update
    always_comb
    begin
        phase_next    = phase_reg;
        stop_next     = stop_reg;
        spd_mag_next  = spd_mag_reg;
        spd_neg_next  = spd_neg_reg;
        str_mag_next  = str_mag_reg;
        str_neg_next  = str_neg_reg;
        flags_next    = flags_reg;
        elapsed_next  = elapsed_reg;
        steer_next    = steer_reg;
        throttle_next = throttle_reg;
        drive         = 1'b0;
        stop_hit      = 1'b0;

        if (in_data.cmd == CMD_TICK) begin
            if (elapsed_reg != TIME_MAX) begin
                elapsed_next = elapsed_reg + 16'd1;
            end
        end else if (c == CH_NL) begin
            // End of line: act on it, then start afresh
            if (stop_reg == STOP_FULL) begin
                steer_next    = neutral_reg;
                throttle_next = neutral_reg;
                stop_hit      = 1'b1;
            end else if (in_str && flags_reg[1]) begin
                throttle_next = to_pulse(spd_mag_reg, spd_neg_reg);
                steer_next    = to_pulse(str_mag_reg, str_neg_reg);
                elapsed_next  = '0;
                drive         = 1'b1;
            end
            phase_next   = PH_LEAD;
            stop_next    = STOP_NONE;
            spd_mag_next = '0;
            spd_neg_next = 1'b0;
            str_mag_next = '0;
            str_neg_next = 1'b0;
            flags_next   = '0;
        end else if (phase_reg == PH_LEAD) begin
            if (!blank) begin
                if (c == CH_S) begin
                    stop_next  = STOP_S;
                    phase_next = PH_SPD_WS;
                end else begin
                    stop_next  = STOP_DEAD;
                    phase_next = PH_JUNK;
                end
            end
        end else begin
            // STOP word tracking runs alongside the S parse
            if (stop_reg < STOP_FULL) begin
                stop_next = (c == stop_char(stop_reg[1:0])) ? stop_reg + 3'd1
                                                            : STOP_DEAD;
            end else if ((stop_reg == STOP_FULL) && !blank) begin
                stop_next = STOP_DEAD;
            end

            if (in_spd) begin
                if (c == CH_SPACE) begin
                    phase_next = flags_reg[0] ? PH_STR_WS : PH_JUNK;
                end else begin
                    flags_next[0] = 1'b1;
                    spd_mag_next  = spd_new.mag;
                    spd_neg_next  = spd_new.neg;
                    unique case (spd_new.sub)
                        NUM_WS:   phase_next = PH_SPD_WS;
                        NUM_SIGN: phase_next = PH_SPD_SIGN;
                        NUM_DIG:  phase_next = PH_SPD_DIG;
                        default:  phase_next = PH_SPD_DONE;
                    endcase
                end
            end else if (in_str) begin
                if (!blank) begin
                    flags_next[1] = 1'b1;
                end
                str_mag_next = str_new.mag;
                str_neg_next = str_new.neg;
                unique case (str_new.sub)
                    NUM_WS:   phase_next = PH_STR_WS;
                    NUM_SIGN: phase_next = PH_STR_SIGN;
                    NUM_DIG:  phase_next = PH_STR_DIG;
                    default:  phase_next = PH_STR_DONE;
                endcase
            end
        end

        // Failsafe check after every request
        failsafe = elapsed_next > timeout_reg;
        if (failsafe) begin
            steer_next    = neutral_reg;
            throttle_next = neutral_reg;
        end

        out_data_next.steer_us        = steer_next;
        out_data_next.throttle_us     = throttle_next;
        out_data_next.drive_applied   = drive;
        out_data_next.stop_applied    = stop_hit;
        out_data_next.failsafe_active = failsafe;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            timeout_reg <= RESET_TIMEOUT;
            neutral_reg <= RESET_PULSE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                default:     neutral_reg <= cfg_wdata[PULSE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_LEAD;
            stop_reg      <= STOP_NONE;
            spd_mag_reg   <= '0;
            spd_neg_reg   <= 1'b0;
            str_mag_reg   <= '0;
            str_neg_reg   <= 1'b0;
            flags_reg     <= '0;
            elapsed_reg   <= '0;
            steer_reg     <= RESET_PULSE;
            throttle_reg  <= RESET_PULSE;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg     <= phase_next;
                stop_reg      <= stop_next;
                spd_mag_reg   <= spd_mag_next;
                spd_neg_reg   <= spd_neg_next;
                str_mag_reg   <= str_mag_next;
                str_neg_reg   <= str_neg_next;
                flags_reg     <= flags_next;
                elapsed_reg   <= elapsed_next;
                steer_reg     <= steer_next;
                throttle_reg  <= throttle_next;
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
